// ===== rtl/tspps_pkg.sv =====
// Shared constants and types for the transport stream PID/PCR statistics block.
// No dependencies.
package tspps_pkg;

    localparam int PID_DEPTH = 512;
    localparam int SLOT_W    = $clog2(PID_DEPTH);
    localparam int FILL_W    = $clog2(PID_DEPTH + 1);
    localparam int HDR_LAST  = 11;
    localparam int OUT_W     = 154;
    localparam int OUT_BYTES = (OUT_W + 7) / 8;

    typedef struct packed {
        logic        has_pcr;
        logic [31:0] gap;
        logic [31:0] packets;
    } t_entry;

    typedef enum logic [6:0] {
        S_RX   = 7'b0000001,
        S_CALC = 7'b0000010,
        S_SRD  = 7'b0000100,
        S_SCMP = 7'b0001000,
        S_ERD  = 7'b0010000,
        S_EWR  = 7'b0100000,
        S_FULL = 7'b1000000
    } t_state;

endpackage

// ===== rtl/ts_pid_pcr_statistics.sv =====
// Top level of the transport stream PID/PCR statistics block.
// Depends on tspps_pkg.
//
// channel  dir  handshake           payload
// s        in   i_s_tvalid/o_s_tready  tdata[7:0] data_byte, tlast packet_end
// m        out  o_m_tvalid/i_m_tready  tdata: pid, pid_packets, total_packets,
//                                      pcr_captured, pcr_ticks,
//                                      pcr_discontinuity, pcr_gap, table_full
//
// Header bytes are accepted while o_s_tready is high. After the last beat of a
// packet the block holds o_s_tready low while it searches the PID key memory
// linearly, one read and one compare per entry. A hit then reads and rewrites
// the entry; a new PID takes the next free slot and starts from a cleared
// entry; a full table yields a table_full beat instead. Reset clears the fill
// count and the total packet counter; no clearing pass is needed since
// entries are initialized when inserted. A stalled output holds the block.
module ts_pid_pcr_statistics (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,  // [7:0] data_byte
    input  logic                            i_s_tlast,  // packet_end
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [12:0] pid, [44:13] pid_packets, [76:45] total_packets,
    // [77] pcr_captured, [119:78] pcr_ticks, [120] pcr_discontinuity,
    // [152:121] pcr_gap, [153] table_full, [159:154] zero
    output logic [tspps_pkg::OUT_BYTES*8-1:0] o_m_tdata
);
    import tspps_pkg::*;

    t_state r_state;
    logic [7:0] r_off;
    logic [7:0] r_hdr [1:HDR_LAST];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_idx;
    logic [SLOT_W-1:0] r_slot;
    logic              r_new;
    logic [12:0] r_pid;
    logic        r_pcr_flag;
    logic        r_disc;
    logic [41:0] r_pcr;
    logic [31:0] r_total;
    logic [12:0] r_key_q;
    t_entry      r_ent_q;
    logic        r_out_valid;
    logic [OUT_BYTES*8-1:0] r_out;

    // PID keys and per-PID counters live in memories
    logic [12:0] r_keys [PID_DEPTH];
    t_entry      r_ents [PID_DEPTH];

    logic   s_acc;
    logic   key_we;
    logic   ent_we;
    t_entry n_ent;
    t_entry cur;
    logic [31:0] gap1;
    logic [32:0] base;
    logic [41:0] b42;

    assign s_acc = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_RX);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    assign base = {r_hdr[6], r_hdr[7], r_hdr[8], r_hdr[9], r_hdr[10][7]};
    assign b42  = {9'd0, base};

    // A freshly inserted entry reads as cleared
    assign cur  = r_new ? '0 : r_ent_q;
    assign gap1 = cur.has_pcr ? cur.gap + 32'd1 : cur.gap;

    always_comb begin
        n_ent.packets = cur.packets + 32'd1;
        n_ent.has_pcr = cur.has_pcr | r_pcr_flag;
        n_ent.gap     = r_pcr_flag ? 32'd0 : gap1;
    end

    assign key_we = (r_state == S_SRD) && (r_idx == r_fill) &&
                    (r_fill < FILL_W'(PID_DEPTH));
    assign ent_we = (r_state == S_EWR) && !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_keys[r_fill[SLOT_W-1:0]] <= r_pid;
        end
        r_key_q <= r_keys[r_idx[SLOT_W-1:0]];
        if (ent_we) begin
            r_ents[r_slot] <= n_ent;
        end
        r_ent_q <= r_ents[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RX;
            r_off       <= '0;
            r_fill      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            for (int k = 1; k <= HDR_LAST; k++) begin
                r_hdr[k] <= '0;
            end
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_RX: begin
                    if (s_acc) begin
                        // capture header bytes 1..11, saturate offset
                        for (int k = 1; k <= HDR_LAST; k++) begin
                            if (r_off == 8'(k)) begin
                                r_hdr[k] <= i_s_tdata;
                            end
                        end
                        if (r_off != 8'hFF) begin
                            r_off <= r_off + 8'd1;
                        end
                        if (i_s_tlast) begin
                            r_state <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    r_pid      <= {r_hdr[1][4:0], r_hdr[2]};
                    r_pcr_flag <= r_hdr[3][5] && r_hdr[5][4];
                    r_disc     <= r_hdr[5][7];
                    // base * 300 as shifted adds
                    r_pcr <= (b42 << 8) + (b42 << 5) + (b42 << 3) + (b42 << 2)
                             + {33'd0, r_hdr[10][0], r_hdr[11]};
                    r_off <= '0;
                    for (int k = 1; k <= HDR_LAST; k++) begin
                        r_hdr[k] <= '0;
                    end
                    r_idx   <= '0;
                    r_state <= S_SRD;
                end
                S_SRD: begin
                    if (r_idx == r_fill) begin
                        if (key_we) begin
                            r_slot  <= r_fill[SLOT_W-1:0];
                            r_new   <= 1'b1;
                            r_fill  <= r_fill + FILL_W'(1);
                            r_state <= S_ERD;
                        end else begin
                            r_state <= S_FULL;
                        end
                    end else begin
                        r_state <= S_SCMP;
                    end
                end
                S_SCMP: begin
                    if (r_key_q == r_pid) begin
                        r_slot  <= r_idx[SLOT_W-1:0];
                        r_new   <= 1'b0;
                        r_state <= S_ERD;
                    end else begin
                        r_idx   <= r_idx + FILL_W'(1);
                        r_state <= S_SRD;
                    end
                end
                S_ERD: begin
                    r_state <= S_EWR;
                end
                S_EWR: begin
                    if (!r_out_valid) begin
                        r_total     <= r_total + 32'd1;
                        r_out_valid <= 1'b1;
                        r_out <= {6'd0, 1'b0,
                                  r_pcr_flag ? gap1 : 32'd0,
                                  r_pcr_flag & r_disc,
                                  r_pcr_flag ? r_pcr : 42'd0,
                                  r_pcr_flag,
                                  r_total + 32'd1,
                                  n_ent.packets,
                                  r_pid};
                        r_state <= S_RX;
                    end
                end
                S_FULL: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out <= {6'd0, 1'b1, 32'd0, 1'b0, 42'd0, 1'b0,
                                  r_total, 32'd0, r_pid};
                        r_state <= S_RX;
                    end
                end
                default: r_state <= S_RX;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output beat dropped while stalled");
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(PID_DEPTH))
        else $error("PID table fill count overflow");
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCMP |-> r_idx < r_fill)
        else $error("search past filled entries");
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) && o_m_tdata[153] |-> r_fill == FILL_W'(PID_DEPTH))
        else $error("table_full with free entries");
`endif

endmodule
